// File: hw/rtl/ots_pkg.sv
package ots_pkg;

    // Fixed field widths of the stream and configuration interfaces.
    localparam int TRIM_W  = 8;
    localparam int FIELD_W = 12;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Input tdata: start_trim [7:0], tick_count [19:8], zero pad to 24 bits.
    localparam int S_TDATA_W = 24;
    // Output tdata: trim_value [7:0], trim_write [8], done_res [9],
    // calibrated [10], final_count [22:11], zero pad to 24 bits.
    localparam int M_TDATA_W = 24;

    // Trim limits for the two trim modes.
    localparam logic [TRIM_W-1:0] WIDE_LIMIT   = 8'hFF;
    localparam logic [TRIM_W-1:0] NARROW_LIMIT = 8'h1F;

    // Register reset values.
    localparam logic               WIDE_MODE_RST   = 1'b1;
    localparam logic [FIELD_W-1:0] TARGET_RST      = 12'd1000;
    localparam logic [FIELD_W-1:0] HIGH_BOUND_RST  = 12'd2000;

    // Register indexes (word address paddr[3:2]).
    typedef enum logic [1:0] {
        REG_WIDE_MODE  = 2'd0,
        REG_TARGET     = 2'd1,
        REG_HIGH_BOUND = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    // Input operation carried in tuser.
    typedef enum logic {
        OP_START   = 1'b0,
        OP_MEASURE = 1'b1
    } op_t;

endpackage

// File: hw/rtl/oscillator_trim_search_unit.sv
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while the output drains; every beat gives exactly one result beat.
// The whole search step is a single compare/increment/decrement stage in front of the
// output register, so a stalled output only blocks input once that register is full.
// Reset (aresetn low, synchronous) restores the registers to their defaults,
// clears the search record and leaves the block idle with no result pending.
module oscillator_trim_search_unit #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Input channel.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] start_trim, [19:8] tick_count, [23:20] zero.
    input  logic [ots_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // [0] op: 0 starts a search, 1 delivers a measurement.
    input  logic                                s_axis_tuser,

    // Result channel.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] trim_value, [8] trim_write, [9] done_res, [10] calibrated,
    // [22:11] final_count, [23] zero.
    output logic [ots_pkg::M_TDATA_W-1:0]       m_axis_tdata,

    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ots_pkg::ADDR_W-1:0]          paddr,
    input  logic [ots_pkg::DATA_W-1:0]          pwdata,
    output logic [ots_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    // Counts are compared at the wider of the field width and COUNT_WIDTH, so
    // register values beyond the saturation point still compare correctly.
    localparam int CMP_W = (COUNT_WIDTH > ots_pkg::FIELD_W) ? COUNT_WIDTH : ots_pkg::FIELD_W;
    localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam int TW = ots_pkg::TRIM_W;
    localparam int FW = ots_pkg::FIELD_W;

    // ------------------------------------------------------------------
    // Configuration registers. pready is tied high, so every access cycle
    // completes at once. Reads return the stored register value.
    // ------------------------------------------------------------------
    logic                 wide_mode_reg;
    logic [FW-1:0]        target_reg;
    logic [FW-1:0]        high_bound_reg;
    logic                 cfg_write;
    ots_pkg::reg_idx_t    cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = ots_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_mode_reg  <= ots_pkg::WIDE_MODE_RST;
            target_reg     <= ots_pkg::TARGET_RST;
            high_bound_reg <= ots_pkg::HIGH_BOUND_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                ots_pkg::REG_WIDE_MODE:  wide_mode_reg  <= pwdata[0];
                ots_pkg::REG_TARGET:     target_reg     <= pwdata[FW-1:0];
                ots_pkg::REG_HIGH_BOUND: high_bound_reg <= pwdata[FW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            ots_pkg::REG_WIDE_MODE:  prdata = {{(ots_pkg::DATA_W-1){1'b0}}, wide_mode_reg};
            ots_pkg::REG_TARGET:     prdata = {{(ots_pkg::DATA_W-FW){1'b0}}, target_reg};
            ots_pkg::REG_HIGH_BOUND: prdata = {{(ots_pkg::DATA_W-FW){1'b0}}, high_bound_reg};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Search state.
    // ------------------------------------------------------------------
    logic [TW-1:0]    cur_trim_reg,   cur_trim_next;
    logic [TW-1:0]    orig_trim_reg,  orig_trim_next;
    logic [TW-1:0]    low_trim_reg,   low_trim_next;
    logic [TW-1:0]    high_trim_reg,  high_trim_next;
    logic [CMP_W-1:0] low_best_reg,   low_best_next;
    logic [CMP_W-1:0] high_best_reg,  high_best_next;
    logic [CMP_W-1:0] orig_count_reg, orig_count_next;
    logic             seen_low_reg,   seen_low_next;
    logic             seen_high_reg,  seen_high_next;
    logic             searching_reg,  searching_next;

    // Output register.
    logic             out_valid_reg;
    logic [TW-1:0]    out_trim_reg,   out_trim_next;
    logic             out_write_reg,  out_write_next;
    logic             out_done_reg,   out_done_next;
    logic             out_cal_reg,    out_cal_next;
    logic [FW-1:0]    out_count_reg,  out_count_next;

    // The input is taken whenever the output register is empty or drains now.
    logic             in_accept;
    logic             out_accept;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = m_axis_tvalid && m_axis_tready;

    // Decoded input beat.
    ots_pkg::op_t     op;
    logic [TW-1:0]    start_trim;
    logic [CMP_W-1:0] tick_raw;
    logic [CMP_W-1:0] tick_sat;
    logic [TW-1:0]    limit;

    assign op         = ots_pkg::op_t'(s_axis_tuser);
    assign start_trim = s_axis_tdata[TW-1:0];
    assign tick_raw   = CMP_W'(s_axis_tdata[TW+FW-1:TW]);
    assign tick_sat   = (tick_raw > COUNT_MAX) ? COUNT_MAX : tick_raw;
    assign limit      = wide_mode_reg ? ots_pkg::WIDE_LIMIT : ots_pkg::NARROW_LIMIT;

    logic             stepped;
    logic             stop;
    logic [TW-1:0]    pick_trim;
    logic [CMP_W-1:0] pick_count;

    always_comb begin
        cur_trim_next   = cur_trim_reg;
        orig_trim_next  = orig_trim_reg;
        low_trim_next   = low_trim_reg;
        high_trim_next  = high_trim_reg;
        low_best_next   = low_best_reg;
        high_best_next  = high_best_reg;
        orig_count_next = orig_count_reg;
        seen_low_next   = seen_low_reg;
        seen_high_next  = seen_high_reg;
        searching_next  = searching_reg;

        out_trim_next   = cur_trim_reg;
        out_write_next  = 1'b0;
        out_done_next   = 1'b0;
        out_cal_next    = 1'b0;
        out_count_next  = '0;

        stepped    = 1'b0;
        stop       = 1'b0;
        pick_trim  = orig_trim_reg;
        pick_count = orig_count_reg;

        unique case (op)
            ots_pkg::OP_START: begin
                // A new search starts from the given trim, masked to the limit.
                cur_trim_next   = start_trim & limit;
                orig_trim_next  = start_trim & limit;
                low_trim_next   = '0;
                high_trim_next  = '0;
                low_best_next   = '0;
                high_best_next  = CMP_W'(high_bound_reg);
                orig_count_next = '0;
                seen_low_next   = 1'b0;
                seen_high_next  = 1'b0;
                searching_next  = 1'b1;
                out_trim_next   = start_trim & limit;
            end
            ots_pkg::OP_MEASURE: begin
                // A measurement while idle just echoes the present trim.
                if (searching_reg) begin
                    if (cur_trim_reg == orig_trim_reg) begin
                        orig_count_next = tick_sat;
                    end

                    if (tick_sat <= CMP_W'(target_reg)) begin
                        // Oscillator at or below target: a low point.
                        if (tick_sat > low_best_reg) begin
                            low_best_next = tick_sat;
                            low_trim_next = cur_trim_reg;
                            seen_low_next = 1'b1;
                        end
                        if (!seen_high_reg) begin
                            if (cur_trim_reg < limit) begin
                                cur_trim_next = cur_trim_reg + TW'(1);
                                stepped       = 1'b1;
                            end else begin
                                stop = 1'b1;
                            end
                        end
                    end else begin
                        // Oscillator above target: a high point.
                        if (tick_sat < high_best_reg) begin
                            high_best_next = tick_sat;
                            high_trim_next = cur_trim_reg;
                            seen_high_next = 1'b1;
                        end
                        if (!seen_low_reg) begin
                            if (cur_trim_reg == '0) begin
                                stop = 1'b1;
                            end else begin
                                cur_trim_next = cur_trim_reg - TW'(1);
                                stepped       = 1'b1;
                            end
                        end
                    end

                    // Best high point wins, then best low point, then the start.
                    priority if (seen_high_next) begin
                        pick_trim  = high_trim_next;
                        pick_count = high_best_next;
                    end else if (seen_low_next) begin
                        pick_trim  = low_trim_next;
                        pick_count = low_best_next;
                    end else begin
                        pick_trim  = orig_trim_reg;
                        pick_count = orig_count_next;
                    end

                    if (!stop && (cur_trim_next != orig_trim_reg)
                            && !(seen_low_next && seen_high_next)) begin
                        out_trim_next  = cur_trim_next;
                        out_write_next = stepped;
                    end else begin
                        out_trim_next  = pick_trim;
                        out_write_next = (pick_trim != cur_trim_next);
                        out_done_next  = 1'b1;
                        out_cal_next   = seen_high_next || seen_low_next;
                        out_count_next = pick_count[FW-1:0];
                        cur_trim_next  = pick_trim;
                        searching_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_trim_reg   <= '0;
            orig_trim_reg  <= '0;
            low_trim_reg   <= '0;
            high_trim_reg  <= '0;
            low_best_reg   <= '0;
            high_best_reg  <= CMP_W'(ots_pkg::HIGH_BOUND_RST);
            orig_count_reg <= '0;
            seen_low_reg   <= 1'b0;
            seen_high_reg  <= 1'b0;
            searching_reg  <= 1'b0;
        end else if (in_accept) begin
            cur_trim_reg   <= cur_trim_next;
            orig_trim_reg  <= orig_trim_next;
            low_trim_reg   <= low_trim_next;
            high_trim_reg  <= high_trim_next;
            low_best_reg   <= low_best_next;
            high_best_reg  <= high_best_next;
            orig_count_reg <= orig_count_next;
            seen_low_reg   <= seen_low_next;
            seen_high_reg  <= seen_high_next;
            searching_reg  <= searching_next;
        end
    end

    // Output valid: set by an accepted input beat, cleared when the beat drains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= 1'b1;
        end else if (out_accept) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload needs no reset; it loads with every accepted beat.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_trim_reg  <= out_trim_next;
            out_write_reg <= out_write_next;
            out_done_reg  <= out_done_next;
            out_cal_reg   <= out_cal_next;
            out_count_reg <= out_count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_count_reg, out_cal_reg, out_done_reg,
                            out_write_reg, out_trim_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_cal_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_cal_reg) |-> out_done_reg)
        else $error("calibrated set on a result that is not done");

    a_count_only_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !out_done_reg) |-> (out_count_reg == '0))
        else $error("final_count nonzero on a result that is not done");

    a_start_begins_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (op == ots_pkg::OP_START)) |=> (searching_reg && !out_done_reg))
        else $error("start beat did not open a search");

    a_idle_measure_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (op == ots_pkg::OP_MEASURE) && !searching_reg)
            |=> (!out_write_reg && !out_done_reg && !searching_reg))
        else $error("measurement while idle changed the trim or finished a search");

    a_done_ends_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && out_done_next) |=> !searching_reg)
        else $error("search still running after a done result");

endmodule
